FILE: design/osdp_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// osdp_frame_receiver_macros
// assertion macros used by the frame receiver checker
// ----------------------------------------------------------------------------
`ifndef OSDP_FRAME_RECEIVER_MACROS_SVH
`define OSDP_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, disabled in reset
`define OSDP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define OSDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/osdp_pkg.sv
// ----------------------------------------------------------------------------
// osdp_pkg
// types, constants and the crc step shared by the frame receiver modules
// ----------------------------------------------------------------------------
package osdp_pkg;

    localparam logic [10:0] MAX_FRAME       = 11'd1024;
    localparam logic [10:0] MIN_FRAME       = 11'd7;
    localparam logic [15:0] CRC_INIT        = 16'h1D0F;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [7:0]  START_MARK      = 8'h53;
    localparam logic [10:0] MAX_FRAME_RESET = 11'd1024;
    localparam logic [19:0] TIMEOUT_RESET   = 20'd5000;

    localparam logic [1:0] CFG_MAX_FRAME_LENGTH = 2'd0;
    localparam logic [1:0] CFG_IDLE_TIMEOUT_US  = 2'd1;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_SUMMARY   = 2'd0,
        KIND_MALFORMED = 2'd1,
        KIND_TIMEOUT   = 2'd2
    } t_result_kind;

    typedef struct packed {
        t_result_kind kind;
        logic [6:0]   address;
        logic [7:0]   control;
        logic [7:0]   command;
        logic         sec_present;
        logic         check_ok;
        logic [9:0]   body_length;
        logic [10:0]  frame_length;
    } t_result;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            crc = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

FILE: design/osdp_rx_core.sv
// ----------------------------------------------------------------------------
// osdp_rx_core
// frame state and combinational byte/tick processing
// ----------------------------------------------------------------------------
module osdp_rx_core
    import osdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_time_us,
    input  logic [10:0] i_max_frame_length,
    input  logic [19:0] i_idle_timeout_us,
    output logic        o_result_valid,
    output t_result     o_result
);

    logic [10:0] r_byte_count,  n_byte_count;
    logic [10:0] r_expected,    n_expected;
    logic [31:0] r_last_time,   n_last_time;
    logic [15:0] r_crc,         n_crc;
    logic [7:0]  r_sum,         n_sum;
    logic [6:0]  r_hdr_address, n_hdr_address;
    logic [7:0]  r_hdr_control, n_hdr_control;
    logic [7:0]  r_hdr_command, n_hdr_command;
    logic [7:0]  r_lag_a,       n_lag_a;
    logic [7:0]  r_lag_b,       n_lag_b;

    logic [10:0] limit;
    logic [31:0] elapsed;
    logic [15:0] full_length;
    logic [10:0] count_inc;
    logic        use_crc;
    logic        clear;

    always_comb begin
        limit       = (i_max_frame_length < MAX_FRAME) ? i_max_frame_length : MAX_FRAME;
        elapsed     = i_time_us - r_last_time;
        full_length = {i_data_byte, r_expected[7:0]};
        count_inc   = r_byte_count + 11'd1;
        use_crc     = r_hdr_control[2];
        clear       = 1'b0;

        n_byte_count  = r_byte_count;
        n_expected    = r_expected;
        n_last_time   = r_last_time;
        n_crc         = r_crc;
        n_sum         = r_sum;
        n_hdr_address = r_hdr_address;
        n_hdr_control = r_hdr_control;
        n_hdr_command = r_hdr_command;
        n_lag_a       = r_lag_a;
        n_lag_b       = r_lag_b;

        o_result_valid = 1'b0;
        o_result       = '0;

        if (i_req_type == REQ_TICK) begin
            if (r_byte_count != 11'd0 && elapsed > {12'd0, i_idle_timeout_us}) begin
                o_result_valid      = 1'b1;
                o_result.kind       = KIND_TIMEOUT;
                o_result.frame_length = r_byte_count;
                clear               = 1'b1;
            end
        end else begin
            n_last_time = i_time_us;
            if (r_byte_count != 11'd0 || i_data_byte == START_MARK) begin
                if (r_byte_count >= 11'd2) begin
                    n_crc = crc_feed(r_crc, r_lag_a);
                end
                n_lag_a      = r_lag_b;
                n_lag_b      = i_data_byte;
                n_sum        = r_sum + i_data_byte;
                n_byte_count = count_inc;
                case (r_byte_count)
                    11'd1:   n_hdr_address = i_data_byte[6:0];
                    11'd2:   n_expected    = {3'd0, i_data_byte};
                    11'd3:   n_expected    = full_length[10:0];
                    11'd4:   n_hdr_control = i_data_byte;
                    11'd5:   n_hdr_command = i_data_byte;
                    default: ;
                endcase

                if (r_byte_count == 11'd3 &&
                    (full_length < {5'd0, MIN_FRAME} || full_length > {5'd0, limit})) begin
                    clear = 1'b1;
                end else if (count_inc >= 11'd4 && count_inc == n_expected) begin
                    o_result_valid = 1'b1;
                    clear          = 1'b1;
                    o_result.frame_length = count_inc;
                    if (use_crc && count_inc == MIN_FRAME) begin
                        o_result.kind = KIND_MALFORMED;
                    end else begin
                        o_result.kind         = KIND_SUMMARY;
                        o_result.address      = r_hdr_address;
                        o_result.control      = r_hdr_control;
                        o_result.command      = r_hdr_command;
                        o_result.sec_present  = r_hdr_control[3];
                        o_result.check_ok     = use_crc ? (n_crc == {i_data_byte, r_lag_b})
                                                        : (n_sum == 8'd0);
                        o_result.body_length =
                            10'(count_inc - 11'd7 - {10'd0, use_crc});
                    end
                end
            end
        end

        if (clear) begin
            n_byte_count  = '0;
            n_expected    = '0;
            n_crc         = CRC_INIT;
            n_sum         = '0;
            n_hdr_address = '0;
            n_hdr_control = '0;
            n_hdr_command = '0;
            n_lag_a       = '0;
            n_lag_b       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_expected    <= '0;
            r_last_time   <= '0;
            r_crc         <= CRC_INIT;
            r_sum         <= '0;
            r_hdr_address <= '0;
            r_hdr_control <= '0;
            r_hdr_command <= '0;
            r_lag_a       <= '0;
            r_lag_b       <= '0;
        end else if (i_accept) begin
            r_byte_count  <= n_byte_count;
            r_expected    <= n_expected;
            r_last_time   <= n_last_time;
            r_crc         <= n_crc;
            r_sum         <= n_sum;
            r_hdr_address <= n_hdr_address;
            r_hdr_control <= n_hdr_control;
            r_hdr_command <= n_hdr_command;
            r_lag_a       <= n_lag_a;
            r_lag_b       <= n_lag_b;
        end
    end

endmodule

FILE: design/osdp_frame_receiver.sv
// ----------------------------------------------------------------------------
// osdp_frame_receiver
// osdp frame receiver with crc-16 or 8-bit checksum check
// ----------------------------------------------------------------------------
// input channel: one beat is a received byte or a time tick (i_req_type),
// with the byte and the current microsecond time; a beat moves when
// i_in_valid is high and o_in_stall is low.
// output channel: one beat is a frame summary, a malformed-frame fault or an
// idle-timeout fault; it moves when o_out_valid is high and i_out_stall low.
// config channel: i_cfg_index 0 sets the frame length limit, 1 the idle
// timeout; o_cfg_ready is always high. write only while the block is idle.
// every input beat is processed combinationally; a beat that ends the frame
// or trips the timeout has its result registered in the output register
// (skid register if stalled). one beat per cycle while o_in_stall is low.
// when the receiver stalls, one further result is held in a skid register
// and o_in_stall rises until it drains; beats that give no result still
// need a free skid slot to be taken.
// reset (synchronous, active low) empties the output, restores the default
// limit and timeout and returns the receiver to start-mark hunting.
// ----------------------------------------------------------------------------
module osdp_frame_receiver
    import osdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_time_us,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [6:0]  o_address,
    output logic [7:0]  o_control,
    output logic [7:0]  o_command,
    output logic        o_sec_present,
    output logic        o_check_ok,
    output logic [9:0]  o_body_length,
    output logic [10:0] o_frame_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    logic [10:0] r_max_frame_length;
    logic [19:0] r_idle_timeout_us;
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        in_accept;
    logic        out_free;
    logic        core_valid;
    t_result     core_result;

    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    osdp_rx_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (in_accept),
        .i_req_type         (i_req_type),
        .i_data_byte        (i_data_byte),
        .i_time_us          (i_time_us),
        .i_max_frame_length (r_max_frame_length),
        .i_idle_timeout_us  (r_idle_timeout_us),
        .o_result_valid     (core_valid),
        .o_result           (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_length <= MAX_FRAME_RESET;
            r_idle_timeout_us  <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_FRAME_LENGTH: r_max_frame_length <= i_cfg_data[10:0];
                CFG_IDLE_TIMEOUT_US:  r_idle_timeout_us  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept && core_valid;
            end
        end else if (in_accept && core_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : core_result;
        end
        if (!out_free && in_accept && core_valid) begin
            r_skid <= core_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out.kind;
    assign o_address      = r_out.address;
    assign o_control      = r_out.control;
    assign o_command      = r_out.command;
    assign o_sec_present  = r_out.sec_present;
    assign o_check_ok     = r_out.check_ok;
    assign o_body_length  = r_out.body_length;
    assign o_frame_length = r_out.frame_length;

endmodule

FILE: design/osdp_frame_receiver_checker.sv
// ----------------------------------------------------------------------------
// osdp_frame_receiver_checker
// port-level checks on the frame receiver results, bound to the top level
// ----------------------------------------------------------------------------
`include "osdp_frame_receiver_macros.svh"

module osdp_frame_receiver_checker
    import osdp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_result_kind,
    input logic [6:0]  o_address,
    input logic [7:0]  o_control,
    input logic [7:0]  o_command,
    input logic        o_sec_present,
    input logic        o_check_ok,
    input logic [9:0]  o_body_length,
    input logic [10:0] o_frame_length
);

    logic        fault_kind;
    logic        hdr_clear;
    logic        summary_ok;
    logic [10:0] summary_length;
    logic [47:0] out_beat;

    assign fault_kind = o_result_kind != KIND_SUMMARY;
    assign summary_length = {1'b0, o_body_length} + 11'd7 + {10'd0, o_control[2]};
    assign hdr_clear = o_address == 7'd0 && o_control == 8'd0 && o_command == 8'd0 &&
                       !o_sec_present && !o_check_ok && o_body_length == 10'd0;
    assign summary_ok = summary_length == o_frame_length && o_sec_present == o_control[3];
    assign out_beat = {o_result_kind, o_address, o_control, o_command, o_sec_present,
                       o_check_ok, o_body_length, o_frame_length};

    `OSDP_ASSERT_NOW(a_fault_fields_zero, i_clk, i_rst_n, o_out_valid && fault_kind, hdr_clear, "fault beat carries header fields")
    `OSDP_ASSERT_NOW(a_summary_length, i_clk, i_rst_n, o_out_valid && !fault_kind, summary_ok, "summary lengths disagree")
    `OSDP_ASSERT_NOW(a_malformed_short, i_clk, i_rst_n, o_out_valid && o_result_kind == KIND_MALFORMED, o_frame_length == 11'd7, "malformed fault on frame not of length seven")
    `OSDP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(out_beat), "stalled result beat changed")

endmodule

bind osdp_frame_receiver osdp_frame_receiver_checker u_checker (.*);

FILE: bench/osdp_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// osdp_frame_receiver_tb
// self-checking bench for the osdp frame receiver: a directed table of bytes
// and ticks, then random frames, broken frames and line noise under six
// limit and timeout settings, with random idling on both channels. each
// accepted beat runs through a behavioral receiver in the bench and every
// report on the output is compared field by field, in order.
// ----------------------------------------------------------------------------
module osdp_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import osdp_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam bit TYPED = 1'b1;
    localparam bit PREDICTED = 1'b0;
    localparam int PHASE_ITEMS = 100;
    localparam int SETTLE = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int unsigned LIM_TAB [6] = '{8, 40, 1024, 300, 8, 1024};
    localparam int unsigned TMO_TAB [6] = '{0, 300, 1000000, 5000, 1000000, 0};
    localparam int SEND_IDLE_TAB [6] = '{14, 14, 78, 78, 0, 0};
    localparam int HOLD_TAB [6] = '{78, 78, 14, 14, 0, 0};

    typedef struct packed {
        logic        req;
        logic [7:0]  data;
        logic [31:0] t_us;
    } t_beat;

    typedef struct {
        t_beat   bt;
        bit      typed;
        bit      want_any;
        t_result want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic [31:0] i_time_us = 32'h0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic [6:0]  o_address;
    logic [7:0]  o_control;
    logic [7:0]  o_command;
    logic        o_sec_present;
    logic        o_check_ok;
    logic [9:0]  o_body_length;
    logic [10:0] o_frame_length;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_MAX_FRAME_LENGTH;
    logic [19:0] i_cfg_data = 20'h0;

    logic [10:0] cfg_max_len;
    logic [19:0] cfg_timeout;
    logic [10:0] rx_count;
    logic [15:0] rx_declared;
    logic [31:0] rx_last_time;
    logic [15:0] rx_crc;
    logic [7:0]  rx_sum;
    logic [6:0]  rx_addr;
    logic [7:0]  rx_ctrl;
    logic [7:0]  rx_cmd;
    logic [7:0]  rx_lag_old;
    logic [7:0]  rx_lag_new;

    t_result report_due[$];
    t_row    drill[$];
    logic [31:0] now_us;
    int n_bad = 0;
    int n_sent = 0;
    int send_idle_pct = 0;
    int hold_pct = 0;
    int quiet_cycles = 0;

    osdp_frame_receiver dut (.*);

    always #10 i_clk = ~i_clk;

    function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
        logic [15:0] r;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            if (r[15] ^ b[k]) r = {r[14:0], 1'b0} ^ CRC_POLY;
            else r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [10:0] frame_limit();
        return (cfg_max_len < MAX_FRAME) ? cfg_max_len : MAX_FRAME;
    endfunction

    task automatic rx_clear();
        rx_count = '0;
        rx_declared = '0;
        rx_crc = CRC_INIT;
        rx_sum = '0;
        rx_addr = '0;
        rx_ctrl = '0;
        rx_cmd = '0;
        rx_lag_old = '0;
        rx_lag_new = '0;
    endtask

    task automatic predict_rx(input t_beat bt, output bit fires, output t_result rep);
        logic [31:0] quiet;
        logic [10:0] lim;
        bit          crc_mode;
        logic [1:0]  tail;
        fires = 1'b0;
        rep = '0;
        lim = frame_limit();
        if (bt.req == REQ_TICK) begin
            quiet = bt.t_us - rx_last_time;
            if (rx_count != 0 && quiet > {12'h0, cfg_timeout}) begin
                rep.kind = KIND_TIMEOUT;
                rep.frame_length = rx_count;
                fires = 1'b1;
                rx_clear();
            end
            return;
        end
        rx_last_time = bt.t_us;
        if (rx_count == 0) begin
            if (bt.data != START_MARK) return;
            rx_clear();
        end
        if (rx_count >= 2) rx_crc = crc16_step(rx_crc, rx_lag_old);
        rx_lag_old = rx_lag_new;
        rx_lag_new = bt.data;
        rx_sum = rx_sum + bt.data;
        case (rx_count)
            11'd1: rx_addr = bt.data[6:0];
            11'd2: rx_declared = {8'h00, bt.data};
            11'd3: rx_declared[15:8] = bt.data;
            11'd4: rx_ctrl = bt.data;
            11'd5: rx_cmd = bt.data;
            default: ;
        endcase
        rx_count = rx_count + 1'b1;
        if (rx_count == 4 && (rx_declared < MIN_FRAME || rx_declared > lim)) begin
            rx_clear();
            return;
        end
        if (rx_count >= 4 && rx_count == rx_declared) begin
            crc_mode = rx_ctrl[2];
            tail = crc_mode ? 2'd2 : 2'd1;
            fires = 1'b1;
            rep.frame_length = rx_count;
            if (rx_count < 6 + tail) begin
                rep.kind = KIND_MALFORMED;
            end else begin
                rep.kind = KIND_SUMMARY;
                rep.address = rx_addr;
                rep.control = rx_ctrl;
                rep.command = rx_cmd;
                rep.sec_present = rx_ctrl[3];
                rep.check_ok = crc_mode ? (rx_crc == {rx_lag_new, rx_lag_old}) : (rx_sum == 0);
                rep.body_length = 10'(rx_count - 6 - tail);
            end
            rx_clear();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_bad++;
        end
    endtask

    task automatic match_report();
        t_result want;
        if (report_due.size() == 0) begin
            $error("report with nothing due: kind %0d, frame_length %0d",
                   o_result_kind, o_frame_length);
            n_bad++;
        end else begin
            want = report_due.pop_front();
            check_field("result_kind", want.kind, o_result_kind);
            check_field("address", want.address, o_address);
            check_field("control", want.control, o_control);
            check_field("command", want.command, o_command);
            check_field("sec_present", want.sec_present, o_sec_present);
            check_field("check_ok", want.check_ok, o_check_ok);
            check_field("body_length", want.body_length, o_body_length);
            check_field("frame_length", want.frame_length, o_frame_length);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < hold_pct);
            if (o_out_valid && !i_out_stall) begin
                match_report();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input t_beat bt, input bit typed, input bit want_any,
                             input t_result want);
        bit      fires;
        t_result rep;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= bt.req;
        i_data_byte <= bt.data;
        i_time_us <= bt.t_us;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
        predict_rx(bt, fires, rep);
        if (typed) begin
            fires = want_any;
            rep = want;
        end
        if (fires) report_due.push_back(rep);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat('{REQ_BYTE, b, now_us}, PREDICTED, 1'b0, '0);
        now_us = now_us + $urandom_range(0, 20);
    endtask

    task automatic send_tick(input logic [31:0] t);
        now_us = t;
        send_beat('{REQ_TICK, 8'($urandom), t}, PREDICTED, 1'b0, '0);
    endtask

    // right at the timeout, one past it, or anywhere near now
    function automatic logic [31:0] pick_tick_time();
        case ($urandom_range(0, 2))
            0: return rx_last_time + cfg_timeout;
            1: return rx_last_time + cfg_timeout + 1;
            default: return now_us + $urandom_range(0, 64);
        endcase
    endfunction

    function automatic logic [15:0] good_len(logic [10:0] lim);
        logic [10:0] top;
        top = ($urandom_range(0, 11) == 0) ? 11'd100 : 11'd24;
        if (top > lim) top = lim;
        return 16'($urandom_range(7, top));
    endfunction

    task automatic send_frame(input logic [15:0] len, input bit cut, input bit bulk);
        logic [7:0]  fb[$];
        logic [7:0]  ctrl;
        logic [15:0] crc;
        logic [7:0]  sum;
        bit          fits;
        int          n_keep;
        int          i;
        if (rx_count != 0) send_tick(rx_last_time + cfg_timeout + 1 + $urandom_range(0, 500));
        ctrl = 8'($urandom);
        if (bulk) ctrl[2] = 1'b0;
        fb = {START_MARK, 8'($urandom), len[7:0], len[15:8], ctrl, 8'($urandom)};
        fits = (len >= MIN_FRAME) && (len <= frame_limit());
        if (fits) begin
            while (fb.size() < len) fb.push_back(8'($urandom));
            if (bulk || $urandom_range(0, 9) != 0) begin
                if (ctrl[2]) begin
                    if (len > MIN_FRAME) begin
                        crc = CRC_INIT;
                        for (i = 0; i < len - 2; i++) crc = crc16_step(crc, fb[i]);
                        fb[len - 2] = crc[7:0];
                        fb[len - 1] = crc[15:8];
                    end
                end else begin
                    sum = 8'h00;
                    for (i = 0; i < len - 1; i++) sum = sum + fb[i];
                    fb[len - 1] = 8'h00 - sum;
                end
            end
        end
        n_keep = fits ? int'(len) : 4;
        if (cut) n_keep = $urandom_range(1, n_keep - 1);
        for (i = 0; i < n_keep; i++) begin
            if (!bulk && $urandom_range(0, 39) == 0) send_tick(pick_tick_time());
            send_byte(fb[i]);
        end
    endtask

    task automatic random_traffic(input int n_items);
        int          start;
        int          r;
        logic [10:0] lim;
        logic [15:0] len;
        start = n_sent;
        while (n_sent - start < n_items) begin
            lim = frame_limit();
            r = $urandom_range(0, 99);
            if (r < 8) begin
                len = $urandom_range(0, 1) ? 16'($urandom_range(0, 6))
                                           : 16'($urandom_range(lim + 1, 65535));
                send_frame(len, 1'b0, 1'b0);
            end else if (r < 16) begin
                send_frame(good_len(lim), 1'b1, 1'b0);
            end else if (r < 26) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1)) send_tick(pick_tick_time());
                    else send_byte(8'($urandom));
                end
            end else begin
                send_frame(good_len(lim), 1'b0, 1'b0);
            end
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [19:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_MAX_FRAME_LENGTH) cfg_max_len = val[10:0];
        else if (idx == CFG_IDLE_TIMEOUT_US) cfg_timeout = val;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (report_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic row(input logic req, input logic [7:0] data, input logic [31:0] t_us,
                       input bit typed, input bit want_any, input t_result_kind kind,
                       input logic [10:0] flen);
        t_row r;
        r.bt = '{req, data, t_us};
        r.typed = typed;
        r.want_any = want_any;
        r.want = '0;
        r.want.kind = kind;
        r.want.frame_length = flen;
        drill.push_back(r);
    endtask

    initial begin
        cfg_max_len = MAX_FRAME_RESET;
        cfg_timeout = TIMEOUT_RESET;
        rx_last_time = '0;
        rx_clear();
        now_us = '0;

        // tick and stray byte while hunting
        row(REQ_TICK, 8'hFF, 32'hFFFF_FFFF, TYPED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'h00, 32'd0, TYPED, 1'b0, KIND_SUMMARY, 11'd0);
        // crc frame of seven bytes is too short for its trailer
        row(REQ_BYTE, START_MARK, 32'd10, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'hFF, 32'd20, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'h07, 32'd30, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'h00, 32'd40, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'h04, 32'd50, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'hAA, 32'd60, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'h00, 32'd70, TYPED, 1'b1, KIND_MALFORMED, 11'd7);
        // shortest checksum frame, secure bit set
        row(REQ_BYTE, START_MARK, 32'd80, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'h00, 32'd90, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'h07, 32'd100, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'h00, 32'd110, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'h08, 32'd120, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'hFF, 32'd130, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'h9F, 32'd140, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        // declared length too short, dropped silently
        row(REQ_BYTE, START_MARK, 32'd150, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'h01, 32'd160, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'h06, 32'd170, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_BYTE, 8'h00, 32'd180, TYPED, 1'b0, KIND_SUMMARY, 11'd0);
        // timeout across the time wrap, exactly at the limit then one past
        row(REQ_BYTE, START_MARK, 32'hFFFF_FF00, PREDICTED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_TICK, 8'h00, 32'h0000_1288, TYPED, 1'b0, KIND_SUMMARY, 11'd0);
        row(REQ_TICK, 8'h00, 32'h0000_1289, TYPED, 1'b1, KIND_TIMEOUT, 11'd1);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = SEND_IDLE_TAB[0];
        hold_pct = HOLD_TAB[0];
        foreach (drill[i]) begin
            send_beat(drill[i].bt, drill[i].typed, drill[i].want_any, drill[i].want);
        end

        for (int p = 0; p < 6; p++) begin
            drain();
            cfg_write(CFG_MAX_FRAME_LENGTH, 20'(LIM_TAB[p]));
            cfg_write(CFG_IDLE_TIMEOUT_US, 20'(TMO_TAB[p]));
            if (p == 1) cfg_write(CFG_SPARE, 20'hFFFFF);
            i_cfg_valid <= 1'b0;
            send_idle_pct = SEND_IDLE_TAB[p];
            hold_pct = HOLD_TAB[p];
            now_us = $urandom;
            if (p == 2) send_frame(16'(MAX_FRAME), 1'b0, 1'b1);
            random_traffic(PHASE_ITEMS);
        end

        drain();
        if (n_bad == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
